[design/sdt_pkg.sv]
`default_nettype none

package sdt_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned CfgW   = 15;
  localparam int unsigned CoordW = 32;
  localparam int unsigned GroupW = 10;

  // Exact width of every bound and diagonal term before scaling to tiles.
  localparam int unsigned ArgW   = 35;

  // Four quadrants, each giving at most two rectangles.
  localparam int unsigned Quads  = 4;
  localparam int unsigned Slots  = 2 * Quads;

  // Register defaults.
  localparam int unsigned DefaultWaveSize = 64;
  localparam logic [CfgW-1:0] ResetExtentWidth  = CfgW'(1920);
  localparam logic [CfgW-1:0] ResetExtentHeight = CfgW'(1080);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CfgExtentWidth  = 1'b0,
    CfgExtentHeight = 1'b1
  } cfg_idx_e;

  // One dispatch rectangle as held in the list and output registers.
  typedef struct packed {
    logic [GroupW-1:0] groups_y;
    logic [GroupW-1:0] groups_z;
    logic [CoordW-1:0] offset_x;
    logic [CoordW-1:0] offset_y;
  } rect_t;

endpackage

`default_nettype wire

[design/sdt_req_if.sv]
`default_nettype none

interface sdt_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [sdt_pkg::CoordW-1:0]   light_x;
  logic signed [sdt_pkg::CoordW-1:0]   light_y;

  modport source (output valid, output light_x, output light_y, input ready);
  modport sink   (input valid, input light_x, input light_y, output ready);
endinterface

`default_nettype wire

[design/sdt_res_if.sv]
`default_nettype none

interface sdt_res_if;
  logic                                valid;
  logic                                ready;
  logic                                valid_res;
  logic                                last;
  logic        [sdt_pkg::GroupW-1:0]   groups_y;
  logic        [sdt_pkg::GroupW-1:0]   groups_z;
  logic signed [sdt_pkg::CoordW-1:0]   offset_x;
  logic signed [sdt_pkg::CoordW-1:0]   offset_y;

  modport source (output valid, output valid_res, output last, output groups_y,
                  output groups_z, output offset_x, output offset_y, input ready);
  modport sink   (input valid, input valid_res, input last, input groups_y,
                  input groups_z, input offset_x, input offset_y, output ready);
endinterface

`default_nettype wire

[design/shadow_dispatch_tiler.sv]
// Channel   | Direction | Handshake     | Payload
// ----------+-----------+---------------+---------------------------------------------
// req_i     | in        | valid/ready   | light_x, light_y
// res_o     | out       | valid/ready   | valid_res, last, groups_y/z, offset_x/y
// cfg       | in        | cfg_we_i      | cfg_idx_i, cfg_wdata_i (extent width/height)
//
// A request passes four register stages, then the output register shows its first result.
// Each light position yields one to eight results, one per cycle from the single output
// register while res_o is not stalled, so a position sends max(1, rectangle count) results.
// Requests are taken every cycle while the stage ahead is free, also during result stalls.
// rst_ni clears all valid flags and restores the extents to 1920 by 1080.
// WAVE_SIZE must be a power of two.

`default_nettype none

module shadow_dispatch_tiler #(
  parameter int unsigned WAVE_SIZE = sdt_pkg::DefaultWaveSize
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  sdt_req_if.sink                        req_i,
  sdt_res_if.source                      res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [sdt_pkg::CfgW-1:0]  cfg_wdata_i
);

  localparam int unsigned WaveLog = $clog2(WAVE_SIZE);
  localparam int unsigned ArgW    = sdt_pkg::ArgW;
  localparam int unsigned BW      = ArgW - WaveLog;
  localparam int unsigned GW      = BW + 1;
  localparam int unsigned CoordW  = sdt_pkg::CoordW;
  localparam int unsigned GroupW  = sdt_pkg::GroupW;
  localparam int unsigned Quads   = sdt_pkg::Quads;
  localparam int unsigned Slots   = sdt_pkg::Slots;

  typedef logic signed [ArgW-1:0] arg_t;

  localparam arg_t WaveM1 = arg_t'(WAVE_SIZE - 1);
  localparam arg_t WaveM2 = arg_t'(2 * WAVE_SIZE - 1);

  // Tile bounds of one quadrant and its diagonal length in tiles.
  typedef struct packed {
    logic [BW-1:0] b0;
    logic [BW-1:0] b1;
    logic [BW-1:0] b2;
    logic [BW-1:0] b3;
    logic [BW-1:0] dc;
    logic          dpos;
  } quad_b_t;

  // Whole quadrant rectangle before the diagonal split.
  typedef struct packed {
    logic signed [GW-1:0] gy;
    logic signed [GW-1:0] gz;
    logic [CoordW-1:0]    ox;
    logic [CoordW-1:0]    oy;
    logic [BW-1:0]        dc;
    logic                 dpos;
    logic                 ok;
  } quad_a_t;

  // Clamp at zero and scale to whole tiles.
  function automatic logic [BW-1:0] clamp_div(arg_t n);
    if (n < 0) begin
      return '0;
    end
    return BW'(n >>> WaveLog);
  endfunction

  // Extent registers.
  logic [sdt_pkg::CfgW-1:0] ext_w_q, ext_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_w_q <= sdt_pkg::ResetExtentWidth;
      ext_h_q <= sdt_pkg::ResetExtentHeight;
    end else if (cfg_we_i) begin
      unique case (sdt_pkg::cfg_idx_e'(cfg_idx_i))
        sdt_pkg::CfgExtentWidth:  ext_w_q <= cfg_wdata_i;
        sdt_pkg::CfgExtentHeight: ext_h_q <= cfg_wdata_i;
        default:                  ext_w_q <= ext_w_q;
      endcase
    end
  end

  // Pipeline valid flags and back-pressure.
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_ready, s2_ready, s3_ready, s4_ready;
  logic out_load, s4_done;

  assign s3_ready    = !s3_valid_q || s4_ready;
  assign s2_ready    = !s2_valid_q || s3_ready;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign req_i.ready = s1_ready;
  assign s4_ready    = !s4_valid_q || s4_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage 1: request register.
  logic signed [CoordW-1:0] s1_lx_q, s1_ly_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && req_i.valid) begin
      s1_lx_q <= req_i.light_x;
      s1_ly_q <= req_i.light_y;
    end
  end

  // Quadrant bounds in tiles and the diagonal length of each quadrant.
  quad_b_t s2_d [Quads];
  quad_b_t s2_q [Quads];

  always_comb begin
    arg_t lx, ly, ex, ey, n0, n1, n2, n3, draw, dsum;
    logic odd, hi, vert;
    lx = arg_t'(s1_lx_q);
    ly = arg_t'(s1_ly_q);
    ex = arg_t'(ext_w_q);
    ey = arg_t'(ext_h_q);
    for (int q = 0; q < Quads; q++) begin
      odd  = (q == 1) || (q == 3);
      hi   = (q >= 2);
      vert = (q == 0) || (q == 3);
      n0   = odd ? -lx : (lx - ex);
      n1   = hi ? (ly - ey) : -ly;
      n2   = (odd ? (ex - lx) : lx) + (vert ? WaveM1 : WaveM2);
      n3   = (hi ? ly : (ey - ly)) + (vert ? WaveM2 : WaveM1);
      unique case (q)
        0:       draw = ey - lx - ly;
        1:       draw = ex - lx + ly - ey;
        2:       draw = lx - ly;
        default: draw = lx - ex + ly;
      endcase
      dsum = draw + WaveM1;
      s2_d[q].b0   = clamp_div(n0);
      s2_d[q].b1   = clamp_div(n1);
      s2_d[q].b2   = clamp_div(n2);
      s2_d[q].b3   = clamp_div(n3);
      s2_d[q].dc   = BW'(dsum >>> WaveLog);
      s2_d[q].dpos = (draw > 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // Whole quadrant rectangle: group counts and tile offsets.
  quad_a_t s3_d [Quads];
  quad_a_t s3_q [Quads];

  always_comb begin
    logic [CoordW-1:0] ox, oy;
    for (int q = 0; q < Quads; q++) begin
      s3_d[q].gy = signed'(GW'(s2_q[q].b2)) - signed'(GW'(s2_q[q].b0));
      s3_d[q].gz = signed'(GW'(s2_q[q].b3)) - signed'(GW'(s2_q[q].b1));
      ox = ((q == 1) || (q == 3)) ? CoordW'(s2_q[q].b0) : -CoordW'(s2_q[q].b2);
      oy = (q >= 2) ? -CoordW'(s2_q[q].b3) : CoordW'(s2_q[q].b1);
      s3_d[q].ox   = ox + ((q >= 2) ? CoordW'(1) : '0);
      s3_d[q].oy   = oy + (((q == 1) || (q == 3)) ? CoordW'(1) : '0);
      s3_d[q].ok   = (s3_d[q].gy > 0) && (s3_d[q].gz > 0);
      s3_d[q].dc   = s2_q[q].dc;
      s3_d[q].dpos = s2_q[q].dpos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  // Diagonal split: slot 2q holds the remainder, slot 2q+1 the triangle cover.
  sdt_pkg::rect_t       list_d [Slots];
  logic [Slots-1:0]     mask_d;

  always_comb begin
    logic [GW-1:0]     gyu, gzu, gd, dcu, take, rest_g;
    logic [GroupW-1:0] gy10, gz10, take10, rest10;
    logic [CoordW-1:0] ox, oy;
    for (int q = 0; q < Quads; q++) begin
      gyu    = GW'(s3_q[q].gy);
      gzu    = GW'(s3_q[q].gz);
      gd     = ((q == 0) || (q == 3)) ? gzu : gyu;
      dcu    = GW'(s3_q[q].dc);
      take   = (gd < dcu) ? gd : dcu;
      rest_g = gd - take;
      gy10   = GroupW'(gyu);
      gz10   = GroupW'(gzu);
      take10 = GroupW'(take);
      rest10 = GroupW'(rest_g);
      ox     = s3_q[q].ox;
      oy     = s3_q[q].oy;

      list_d[2*q]   = '{groups_y: gy10, groups_z: gz10, offset_x: ox, offset_y: oy};
      list_d[2*q+1] = '{groups_y: gy10, groups_z: gz10, offset_x: ox, offset_y: oy};
      mask_d[2*q]   = s3_q[q].ok;
      mask_d[2*q+1] = 1'b0;

      if (s3_q[q].dpos) begin
        mask_d[2*q]   = s3_q[q].ok && (rest_g != '0);
        mask_d[2*q+1] = s3_q[q].ok;
        unique case (q)
          0: begin
            list_d[2*q].groups_z   = rest10;
            list_d[2*q+1].groups_y = gy10 + GroupW'(1);
            list_d[2*q+1].groups_z = take10;
            list_d[2*q+1].offset_x = ox - CoordW'(1);
            list_d[2*q+1].offset_y = oy + CoordW'(rest_g);
          end
          1: begin
            list_d[2*q].groups_y   = rest10;
            list_d[2*q+1].groups_y = take10;
            list_d[2*q+1].groups_z = gz10 + GroupW'(1);
            list_d[2*q+1].offset_x = ox + CoordW'(rest_g);
          end
          2: begin
            list_d[2*q].groups_y   = rest10;
            list_d[2*q].offset_x   = ox + CoordW'(take);
            list_d[2*q+1].groups_y = take10;
            list_d[2*q+1].groups_z = gz10 + GroupW'(1);
            list_d[2*q+1].offset_y = oy - CoordW'(1);
          end
          default: begin
            list_d[2*q].groups_z   = rest10;
            list_d[2*q].offset_y   = oy + CoordW'(take);
            list_d[2*q+1].groups_y = gy10 + GroupW'(1);
            list_d[2*q+1].groups_z = take10;
          end
        endcase
      end
    end
  end

  // Slot selection signals, shared by stage 4 and the output register.
  logic [Slots-1:0] pick, rest;
  sdt_pkg::rect_t   sel;

  // Stage 4: rectangle list and the slots still to be sent.
  sdt_pkg::rect_t   s4_list_q [Slots];
  logic [Slots-1:0] s4_rem_q;

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      s4_list_q <= list_d;
      s4_rem_q  <= mask_d;
    end else if (out_load) begin
      s4_rem_q  <= s4_rem_q & ~pick;
    end
  end

  // Lowest pending slot goes next; an empty list sends one marker result.
  assign pick     = s4_rem_q & (~s4_rem_q + Slots'(1));
  assign rest     = s4_rem_q & ~pick;
  assign out_load = s4_valid_q && (!out_valid_q || res_o.ready);
  assign s4_done  = out_load && (rest == '0);

  always_comb begin
    sel = '0;
    for (int i = 0; i < Slots; i++) begin
      if (pick[i]) begin
        sel = s4_list_q[i];
      end
    end
  end

  // Output register, offsets scaled from tiles to pixels.
  sdt_pkg::rect_t out_q;
  logic           out_vres_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.groups_y <= sel.groups_y;
      out_q.groups_z <= sel.groups_z;
      out_q.offset_x <= sel.offset_x << WaveLog;
      out_q.offset_y <= sel.offset_y << WaveLog;
      out_vres_q     <= (s4_rem_q != '0);
      out_last_q     <= (rest == '0);
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.valid_res = out_vres_q;
  assign res_o.last      = out_last_q;
  assign res_o.groups_y  = out_q.groups_y;
  assign res_o.groups_z  = out_q.groups_z;
  assign res_o.offset_x  = signed'(out_q.offset_x);
  assign res_o.offset_y  = signed'(out_q.offset_y);

  // An empty-list marker is the final result and carries no rectangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.valid_res |->
      res_o.last && (res_o.groups_y == '0) && (res_o.groups_z == '0) &&
      (res_o.offset_x == '0) && (res_o.offset_y == '0))
    else $error("empty-list marker malformed");

  // A non-final send keeps the list and retires exactly one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !s4_done |=>
      s4_valid_q && ($countones(s4_rem_q) == $countones($past(s4_rem_q)) - 1))
    else $error("list slot bookkeeping broken");

  // An accepted request always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_valid_q)
    else $error("accepted request lost");

  // A list is released only together with its final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q && !out_load |=> s4_valid_q)
    else $error("list released without final result");

endmodule

`default_nettype wire
